>>> hdl/vas_pkg.sv
// Shared types and constants for the vehicle autonomy supervisor.
package vas_pkg;

   localparam int AGE_BITS    = 16;
   localparam int TORQUE_BITS = 16;
   localparam int CFG_BITS    = 16;
   localparam int SPEED_BITS  = 3;
   localparam int CMP_BITS    = (AGE_BITS > CFG_BITS) ? AGE_BITS : CFG_BITS;

   localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};

   localparam int REQ_BITS    = 12 + 2 * TORQUE_BITS;
   localparam int REQ_TDATA_W = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_BITS    = 7 + 2 * TORQUE_BITS;
   localparam int RSP_TDATA_W = ((RSP_BITS + 7) / 8) * 8;

   // Configuration register indexes.
   localparam logic [1:0] CSR_CMD_TIMEOUT = 2'd0;
   localparam logic [1:0] CSR_HB_TIMEOUT  = 2'd1;
   localparam logic [1:0] CSR_IDLE_HOLD   = 2'd2;
   localparam logic [1:0] CSR_READY_SPEED = 2'd3;

   // Drive-by-wire modes that mean the vehicle follows the autonomy stack.
   localparam logic [2:0] DBW_ROS_A = 3'd3;
   localparam logic [2:0] DBW_ROS_B = 3'd4;

   localparam logic [1:0] MISSION_NONE      = 2'd0;
   localparam logic [1:0] MISSION_PLAN      = 2'd1;
   localparam logic [1:0] MISSION_COMPLETED = 2'd2;
   localparam logic [1:0] MISSION_CANCELLED = 2'd3;

   localparam logic [CFG_BITS-1:0] RESET_CMD_TIMEOUT = 16'd10;
   localparam logic [CFG_BITS-1:0] RESET_HB_TIMEOUT  = 16'd10;
   localparam logic [CFG_BITS-1:0] RESET_IDLE_HOLD   = 16'd1000;
   localparam logic [SPEED_BITS-1:0] RESET_READY_SPEED = 3'd1;

   typedef enum logic [2:0] {
      MODE_DEFAULT     = 3'd0,
      MODE_STARTUP     = 3'd1,
      MODE_IDLE        = 3'd2,
      MODE_ENABLED     = 3'd3,
      MODE_DISENGAGING = 3'd4,
      MODE_CONTROLLED  = 3'd5
   } mode_type;

   // Input item, first field in the highest bits.
   typedef struct packed {
      logic signed [TORQUE_BITS-1:0] torque_right_in;
      logic signed [TORQUE_BITS-1:0] torque_left_in;
      logic [1:0]                    mission_code;
      logic                          mission_update;
      logic                          stop_request;
      logic [SPEED_BITS-1:0]         speed_code;
      logic [2:0]                    drive_mode;
      logic                          heartbeat_seen;
      logic                          command_seen;
   } req_fields_type;

   // Result item, first field in the highest bits.
   typedef struct packed {
      logic                          heartbeat_ok;
      logic                          command_fault;
      logic                          brake_right;
      logic                          brake_left;
      logic signed [TORQUE_BITS-1:0] torque_right_out;
      logic signed [TORQUE_BITS-1:0] torque_left_out;
      logic [2:0]                    mode_state;
   } rsp_fields_type;

endpackage

>>> hdl/vehicle_autonomy_supervisor_top.sv
// Autonomy supervisor state machine with tick input and result register.
//
// Usage: one req_ transaction is one update tick carrying the command and
// heartbeat pulses, drive-by-wire mode, speed code, stop level, mission
// status and the controller torques. Each tick yields exactly one rsp_
// transaction with the new supervisor state, the torque and brake commands
// and the stack fault and heartbeat flags of that tick.
// The result is registered: a tick accepted at an edge shows on rsp_ after
// that edge. Throughput is one tick per cycle while rsp_tready holds high;
// the next-state logic feeds a single result register from the request port.
// A tick is taken while the result register is empty or being drained in
// the same cycle, so a stalled receiver holds the result and back-pressures
// req_tready without losing or repeating anything.
// The csr_ port writes timeouts, the idle hold length and the ready speed
// code; write it only while no tick is in flight.
// Synchronous reset puts the machine in the default state, saturates both
// age counters, engages both brakes and loads the register defaults.
module vehicle_autonomy_supervisor_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // command_seen, heartbeat_seen, drive_mode, speed_code, stop_request,
   // mission_update, mission_code, torque_left_in, torque_right_in
   input  logic [vas_pkg::REQ_TDATA_W-1:0]    req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // mode_state, torque_left_out, torque_right_out, brake_left, brake_right,
   // command_fault, heartbeat_ok
   output logic [vas_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   input  logic                               csr_we,
   input  logic [1:0]                         csr_index,
   input  logic [vas_pkg::CFG_BITS-1:0]       csr_wdata
);

   localparam int AB = vas_pkg::AGE_BITS;
   localparam int TB = vas_pkg::TORQUE_BITS;
   localparam int CB = vas_pkg::CFG_BITS;
   localparam int MB = vas_pkg::CMP_BITS;

   vas_pkg::req_fields_type req;
   logic req_fire;

   logic [CB-1:0] cmd_timeout_ff, hb_timeout_ff, idle_hold_ff;
   logic [vas_pkg::SPEED_BITS-1:0] ready_speed_ff;

   vas_pkg::mode_type mode_ff, mode_in;
   logic [2:0]        prev_mode_ff, prev_mode_in;
   logic [CB-1:0]     hold_ff, hold_in;
   logic [AB-1:0]     cmd_age_ff, cmd_age_in, hb_age_ff, hb_age_in;
   logic [1:0]        mission_ff, mission_in, mission_upd;
   logic signed [TB-1:0] torque_l_ff, torque_l_in, torque_r_ff, torque_r_in;
   logic              brake_l_ff, brake_l_in, brake_r_ff, brake_r_in;

   logic fault, hb_ok, ros_mode, drop_out;

   vas_pkg::rsp_fields_type rsp_ff, rsp_in;
   logic rsp_valid_ff;

   assign req        = vas_pkg::req_fields_type'(req_tdata[vas_pkg::REQ_BITS-1:0]);
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_timeout_ff <= vas_pkg::RESET_CMD_TIMEOUT;
         hb_timeout_ff  <= vas_pkg::RESET_HB_TIMEOUT;
         idle_hold_ff   <= vas_pkg::RESET_IDLE_HOLD;
         ready_speed_ff <= vas_pkg::RESET_READY_SPEED;
      end else if (csr_we) begin
         unique case (csr_index)
            vas_pkg::CSR_CMD_TIMEOUT: cmd_timeout_ff <= csr_wdata;
            vas_pkg::CSR_HB_TIMEOUT:  hb_timeout_ff  <= csr_wdata;
            vas_pkg::CSR_IDLE_HOLD:   idle_hold_ff   <= csr_wdata;
            vas_pkg::CSR_READY_SPEED: ready_speed_ff <= csr_wdata[vas_pkg::SPEED_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Ages, flags and the mission latch as seen by this tick.
   always_comb begin
      if (req.command_seen) cmd_age_in = '0;
      else if (cmd_age_ff == vas_pkg::AGE_MAX) cmd_age_in = vas_pkg::AGE_MAX;
      else cmd_age_in = cmd_age_ff + AB'(1);

      if (req.heartbeat_seen) hb_age_in = '0;
      else if (hb_age_ff == vas_pkg::AGE_MAX) hb_age_in = vas_pkg::AGE_MAX;
      else hb_age_in = hb_age_ff + AB'(1);

      fault = MB'(cmd_age_in) > MB'(cmd_timeout_ff);
      hb_ok = MB'(hb_age_in) < MB'(hb_timeout_ff);
      ros_mode = (req.drive_mode == vas_pkg::DBW_ROS_A) ||
                 (req.drive_mode == vas_pkg::DBW_ROS_B);
      drop_out = !ros_mode || fault || req.stop_request;
      mission_upd = req.mission_update ? req.mission_code : mission_ff;
   end

   // Next state, hold counter and mission latch.
   always_comb begin
      mode_in      = mode_ff;
      prev_mode_in = prev_mode_ff;
      hold_in      = hold_ff;
      mission_in   = mission_upd;
      unique case (mode_ff)
         vas_pkg::MODE_STARTUP: begin
            mission_in = vas_pkg::MISSION_NONE;
            if (hb_ok) begin
               prev_mode_in = vas_pkg::MODE_STARTUP;
               mode_in      = vas_pkg::MODE_IDLE;
            end
         end
         vas_pkg::MODE_IDLE: begin
            mission_in = vas_pkg::MISSION_NONE;
            if (!hb_ok) begin
               mode_in = vas_pkg::MODE_STARTUP;
            end else if (prev_mode_ff > vas_pkg::MODE_STARTUP) begin
               // Fallback hold: count up, then clear once the hold ends.
               if (hold_ff < idle_hold_ff) begin
                  hold_in = hold_ff + CB'(1);
               end else begin
                  prev_mode_in = vas_pkg::MODE_STARTUP;
                  hold_in      = '0;
               end
            end else if (ros_mode) begin
               prev_mode_in = vas_pkg::MODE_IDLE;
               mode_in      = vas_pkg::MODE_ENABLED;
            end
         end
         vas_pkg::MODE_ENABLED: begin
            if (!hb_ok) mode_in = vas_pkg::MODE_STARTUP;
            else if (drop_out) mode_in = vas_pkg::MODE_IDLE;
            else if (mission_upd == vas_pkg::MISSION_PLAN) begin
               prev_mode_in = vas_pkg::MODE_ENABLED;
               mode_in      = vas_pkg::MODE_DISENGAGING;
            end
         end
         vas_pkg::MODE_DISENGAGING: begin
            if (!hb_ok) mode_in = vas_pkg::MODE_STARTUP;
            else if (drop_out) mode_in = vas_pkg::MODE_IDLE;
            else if (req.speed_code == ready_speed_ff) begin
               prev_mode_in = vas_pkg::MODE_DISENGAGING;
               mode_in      = vas_pkg::MODE_CONTROLLED;
            end
         end
         vas_pkg::MODE_CONTROLLED: begin
            if (!hb_ok) mode_in = vas_pkg::MODE_STARTUP;
            else if (drop_out) mode_in = vas_pkg::MODE_IDLE;
            else if (mission_upd == vas_pkg::MISSION_COMPLETED ||
                     mission_upd == vas_pkg::MISSION_CANCELLED) begin
               prev_mode_in = vas_pkg::MODE_CONTROLLED;
               mode_in      = vas_pkg::MODE_ENABLED;
            end
         end
         default: begin
            prev_mode_in = vas_pkg::MODE_DEFAULT;
            mode_in      = vas_pkg::MODE_STARTUP;
         end
      endcase
   end

   // Drive command for the state the tick started in.
   always_comb begin
      torque_l_in = torque_l_ff;
      torque_r_in = torque_r_ff;
      brake_l_in  = brake_l_ff;
      brake_r_in  = brake_r_ff;
      unique case (mode_ff)
         vas_pkg::MODE_STARTUP, vas_pkg::MODE_IDLE, vas_pkg::MODE_ENABLED: begin
            torque_l_in = '0;
            torque_r_in = '0;
            brake_l_in  = 1'b1;
            brake_r_in  = 1'b1;
         end
         vas_pkg::MODE_DISENGAGING, vas_pkg::MODE_CONTROLLED: begin
            torque_l_in = req.torque_left_in;
            torque_r_in = req.torque_right_in;
            brake_l_in  = 1'b0;
            brake_r_in  = 1'b0;
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp_in.mode_state       = mode_in;
      rsp_in.torque_left_out  = torque_l_in;
      rsp_in.torque_right_out = torque_r_in;
      rsp_in.brake_left       = brake_l_in;
      rsp_in.brake_right      = brake_r_in;
      rsp_in.command_fault    = fault;
      rsp_in.heartbeat_ok     = hb_ok;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= vas_pkg::MODE_DEFAULT;
         prev_mode_ff <= vas_pkg::MODE_DEFAULT;
         hold_ff      <= '0;
         cmd_age_ff   <= vas_pkg::AGE_MAX;
         hb_age_ff    <= vas_pkg::AGE_MAX;
         mission_ff   <= vas_pkg::MISSION_NONE;
         torque_l_ff  <= '0;
         torque_r_ff  <= '0;
         brake_l_ff   <= 1'b1;
         brake_r_ff   <= 1'b1;
      end else if (req_fire) begin
         mode_ff      <= mode_in;
         prev_mode_ff <= prev_mode_in;
         hold_ff      <= hold_in;
         cmd_age_ff   <= cmd_age_in;
         hb_age_ff    <= hb_age_in;
         mission_ff   <= mission_in;
         torque_l_ff  <= torque_l_in;
         torque_r_ff  <= torque_r_in;
         brake_l_ff   <= brake_l_in;
         brake_r_ff   <= brake_r_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      rsp_tdata = '0;
      rsp_tdata[vas_pkg::RSP_BITS-1:0] = rsp_ff;
   end

`ifndef SYNTHESIS
   // Every tick leaves the default state, so no result reports it.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_ff.mode_state != vas_pkg::MODE_DEFAULT)
      else $error("result reports the default state");

   // The two brakes are always commanded together.
   assert property (@(posedge clock) disable iff (reset)
      brake_l_ff == brake_r_ff)
      else $error("left and right brakes disagree");

   // A tick without a current heartbeat always lands in startup.
   assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_ff.heartbeat_ok || rsp_ff.mode_state == vas_pkg::MODE_STARTUP)
      else $error("heartbeat lost but state is not startup");

   // Released brakes only come with the drive torques from the request.
   assert property (@(posedge clock) disable iff (reset)
      req_fire && !brake_l_in |-> torque_l_in == req.torque_left_in)
      else $error("brakes released without passing torque");

   // Reset empties the result register.
   assert property (@(posedge clock)
      reset |=> !rsp_valid_ff)
      else $error("result valid after reset");
`endif

endmodule
